// ===== rtl/core/mfar_pkg.sv =====
// ----------------------------------------------------------------------------
// mfar_pkg
// Shared opcodes and the result width for the mixed fraction adder.
// ----------------------------------------------------------------------------
package mfar_pkg;

   localparam int OUT_WIDTH = 32;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_CMP = 1'b1;

endpackage

// ===== rtl/core/mfar_if.sv =====
// ----------------------------------------------------------------------------
// mfar_if
// Request and response channels of the mixed fraction adder.
// ----------------------------------------------------------------------------
interface mfar_req_if #(parameter int PART_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic signed [PART_WIDTH-1:0] a_whole;
   logic        [PART_WIDTH-1:0] a_num;
   logic        [PART_WIDTH-1:0] a_den;
   logic signed [PART_WIDTH-1:0] b_whole;
   logic        [PART_WIDTH-1:0] b_num;
   logic        [PART_WIDTH-1:0] b_den;

   modport source (output valid, opcode, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   input ready);
   modport sink   (input valid, opcode, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   output ready);
endinterface

interface mfar_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mfar_pkg::OUT_WIDTH-1:0]  sum_whole;
   logic        [mfar_pkg::OUT_WIDTH-1:0]  sum_num;
   logic        [mfar_pkg::OUT_WIDTH-1:0]  sum_den;
   logic                                   is_less;
   logic                                   is_equal;

   modport source (output valid, sum_whole, sum_num, sum_den, is_less, is_equal,
                   input ready);
   modport sink   (input valid, sum_whole, sum_num, sum_den, is_less, is_equal,
                   output ready);
   modport mon    (input valid, ready, sum_whole, sum_num, sum_den, is_less, is_equal);
endinterface

// ===== rtl/core/mixed_fraction_add_reduce.sv =====
// ----------------------------------------------------------------------------
// mixed_fraction_add_reduce
// Adds two mixed numbers and reduces the sum, or compares them exactly.
// ----------------------------------------------------------------------------
// One request at a time, bit-serial throughout (W = PART_WIDTH). Both operands
// are normalised by two restoring dividers, the cross products are built by
// shift-add steps and the S_SUM state adds them. A compare then goes on to
// the output register. An add goes on to a binary gcd, one shift or subtract
// per cycle, a shift back of the common power of two with a handover into
// a division of numerator and denominator by the gcd, and then the output
// register. How long the gcd loop runs depends on the operands. The response
// register frees the core, so a new request is taken while the previous
// response waits.
module mixed_fraction_add_reduce #(
   parameter int PART_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   mfar_req_if.sink    req_chan,
   mfar_rsp_if.source  rsp_chan
);

   localparam int W  = PART_WIDTH;
   localparam int DW = 2 * PART_WIDTH;
   localparam int CW = $clog2(DW + 1);
   localparam int OW = mfar_pkg::OUT_WIDTH;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NORM = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_GCD  = 3'd4;
   localparam logic [2:0] S_GSH  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          op_ff, op_in;

   logic signed [W+1:0] aw_ff, aw_in, bw_ff, bw_in;
   logic signed [W+2:0] sw_ff, sw_in;

   logic [DW-1:0] xq_ff, xq_in, xr_ff, xr_in, xd_ff, xd_in;
   logic [DW-1:0] yq_ff, yq_in, yr_ff, yr_in, yd_ff, yd_in;

   logic [DW-1:0] mca_ff, mca_in, mcd_ff, mcd_in;
   logic [W-1:0]  mbd_ff, mbd_in, mbr_ff, mbr_in;
   logic [DW-1:0] accp_ff, accp_in, accq_ff, accq_in, accd_ff, accd_in;

   logic [DW-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [CW-1:0] gk_ff, gk_in;

   logic lt_ff, lt_in, eq_ff, eq_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0] rsp_whole_ff, rsp_whole_in;
   logic [OW-1:0]        rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic                 rsp_less_ff, rsp_less_in, rsp_equal_ff, rsp_equal_in;

   // serial divider steps
   logic [DW:0]   x_trial, y_trial;
   logic          x_ge, y_ge;
   logic [DW:0]   x_sub, y_sub;
   logic [DW-1:0] x_rnext, y_rnext, x_qnext, y_qnext;

   logic [W-1:0]  a_den_fix, b_den_fix;
   logic [DW:0]   s_wide;
   logic          s_carry;
   logic [DW:0]   s_red;
   logic [63:0]   num_ext, den_ext, whole_ext;
   logic          req_fire;

   always_comb begin
      x_trial = {xr_ff, xq_ff[DW-1]};
      y_trial = {yr_ff, yq_ff[DW-1]};
      x_ge    = x_trial >= {1'b0, xd_ff};
      y_ge    = y_trial >= {1'b0, yd_ff};
      x_sub   = x_trial - {1'b0, xd_ff};
      y_sub   = y_trial - {1'b0, yd_ff};
      x_rnext = x_ge ? x_sub[DW-1:0] : x_trial[DW-1:0];
      y_rnext = y_ge ? y_sub[DW-1:0] : y_trial[DW-1:0];
      x_qnext = {xq_ff[DW-2:0], x_ge};
      y_qnext = {yq_ff[DW-2:0], y_ge};
   end

   assign a_den_fix = (req_chan.a_den == '0) ? W'(1) : req_chan.a_den;
   assign b_den_fix = (req_chan.b_den == '0) ? W'(1) : req_chan.b_den;

   assign s_wide  = {1'b0, accp_ff} + {1'b0, accq_ff};
   assign s_carry = s_wide >= {1'b0, accd_ff};
   assign s_red   = s_wide - {1'b0, accd_ff};

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign num_ext   = 64'(xq_ff);
   assign den_ext   = 64'(yq_ff);
   assign whole_ext = 64'(sw_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      aw_in        = aw_ff;
      bw_in        = bw_ff;
      sw_in        = sw_ff;
      xq_in        = xq_ff;
      xr_in        = xr_ff;
      xd_in        = xd_ff;
      yq_in        = yq_ff;
      yr_in        = yr_ff;
      yd_in        = yd_ff;
      mca_in       = mca_ff;
      mcd_in       = mcd_ff;
      mbd_in       = mbd_ff;
      mbr_in       = mbr_ff;
      accp_in      = accp_ff;
      accq_in      = accq_ff;
      accd_in      = accd_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gk_in        = gk_ff;
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_whole_in = rsp_whole_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_less_in  = rsp_less_ff;
      rsp_equal_in = rsp_equal_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.opcode;
               aw_in    = {{2{req_chan.a_whole[W-1]}}, req_chan.a_whole};
               bw_in    = {{2{req_chan.b_whole[W-1]}}, req_chan.b_whole};
               xq_in    = {{W{1'b0}}, req_chan.a_num};
               xd_in    = {{W{1'b0}}, a_den_fix};
               xr_in    = '0;
               yq_in    = {{W{1'b0}}, req_chan.b_num};
               yd_in    = {{W{1'b0}}, b_den_fix};
               yr_in    = '0;
               cnt_in   = '0;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            xq_in  = x_qnext;
            xr_in  = x_rnext;
            yq_in  = y_qnext;
            yr_in  = y_rnext;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               // integer part of each fraction joins its whole part
               aw_in    = aw_ff + {2'b00, x_qnext[W-1:0]};
               bw_in    = bw_ff + {2'b00, y_qnext[W-1:0]};
               mca_in   = {{W{1'b0}}, x_rnext[W-1:0]};
               mcd_in   = {{W{1'b0}}, xd_ff[W-1:0]};
               mbd_in   = yd_ff[W-1:0];
               mbr_in   = y_rnext[W-1:0];
               accp_in  = '0;
               accq_in  = '0;
               accd_in  = '0;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // p = ar*bd, d = ad*bd, q = ad*br
            if (mbd_ff[0]) begin
               accp_in = accp_ff + mca_ff;
               accd_in = accd_ff + mcd_ff;
            end
            if (mbr_ff[0]) begin
               accq_in = accq_ff + mcd_ff;
            end
            mca_in = {mca_ff[DW-2:0], 1'b0};
            mcd_in = {mcd_ff[DW-2:0], 1'b0};
            mbd_in = mbd_ff >> 1;
            mbr_in = mbr_ff >> 1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (op_ff == mfar_pkg::OP_CMP) begin
               if (aw_ff != bw_ff) begin
                  lt_in = aw_ff < bw_ff;
                  eq_in = 1'b0;
               end else begin
                  lt_in = accp_ff < accq_ff;
                  eq_in = accp_ff == accq_ff;
               end
               sw_in    = '0;
               xq_in    = '0;
               yq_in    = DW'(1);
               state_in = S_OUT;
            end else begin
               lt_in    = 1'b0;
               eq_in    = 1'b0;
               sw_in    = {aw_ff[W+1], aw_ff} + {bw_ff[W+1], bw_ff}
                          + {{(W+2){1'b0}}, s_carry};
               accp_in  = s_carry ? s_red[DW-1:0] : s_wide[DW-1:0];
               gx_in    = accd_ff;
               gy_in    = s_carry ? s_red[DW-1:0] : s_wide[DW-1:0];
               gk_in    = '0;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (gx_ff == '0) begin
               gx_in    = gy_ff;
               state_in = S_GSH;
            end else if (gy_ff == '0) begin
               state_in = S_GSH;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               gk_in = gk_ff + CW'(1);
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         S_GSH: begin
            if (gk_ff == '0) begin
               xq_in    = accp_ff;
               xd_in    = gx_ff;
               xr_in    = '0;
               yq_in    = accd_ff;
               yd_in    = gx_ff;
               yr_in    = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               gx_in = {gx_ff[DW-2:0], 1'b0};
               gk_in = gk_ff - CW'(1);
            end
         end
         S_DIV: begin
            xq_in  = x_qnext;
            xr_in  = x_rnext;
            yq_in  = y_qnext;
            yr_in  = y_rnext;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_whole_in = whole_ext[OW-1:0];
               rsp_num_in   = num_ext[OW-1:0];
               rsp_den_in   = den_ext[OW-1:0];
               rsp_less_in  = lt_ff;
               rsp_equal_in = eq_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      aw_ff        <= aw_in;
      bw_ff        <= bw_in;
      sw_ff        <= sw_in;
      xq_ff        <= xq_in;
      xr_ff        <= xr_in;
      xd_ff        <= xd_in;
      yq_ff        <= yq_in;
      yr_ff        <= yr_in;
      yd_ff        <= yd_in;
      mca_ff       <= mca_in;
      mcd_ff       <= mcd_in;
      mbd_ff       <= mbd_in;
      mbr_ff       <= mbr_in;
      accp_ff      <= accp_in;
      accq_ff      <= accq_in;
      accd_ff      <= accd_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      gk_ff        <= gk_in;
      lt_ff        <= lt_in;
      eq_ff        <= eq_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_den_ff   <= rsp_den_in;
      rsp_less_ff  <= rsp_less_in;
      rsp_equal_ff <= rsp_equal_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.sum_whole = rsp_whole_ff;
   assign rsp_chan.sum_num   = rsp_num_ff;
   assign rsp_chan.sum_den   = rsp_den_ff;
   assign rsp_chan.is_less   = rsp_less_ff;
   assign rsp_chan.is_equal  = rsp_equal_ff;

endmodule

// ===== rtl/core/mfar_checker.sv =====
// ----------------------------------------------------------------------------
// mfar_checker
// Port-level checks on the response channel of the mixed fraction adder.
// ----------------------------------------------------------------------------
module mfar_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [mfar_pkg::OUT_WIDTH-1:0] rsp_sum_whole,
   input logic        [mfar_pkg::OUT_WIDTH-1:0] rsp_sum_num,
   input logic        [mfar_pkg::OUT_WIDTH-1:0] rsp_sum_den,
   input logic                                 rsp_is_less,
   input logic                                 rsp_is_equal
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_sum_whole) && $stable(rsp_sum_num)
         && $stable(rsp_sum_den) && $stable(rsp_is_less)
         && $stable(rsp_is_equal))
      else $error("response changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_less && rsp_is_equal))
      else $error("less and equal both set");

   // compare flags only come with the fixed compare fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_less || rsp_is_equal) |->
         rsp_sum_whole == '0 && rsp_sum_num == '0 && rsp_sum_den == 1)
      else $error("compare response carries sum fields");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind mixed_fraction_add_reduce mfar_checker u_mfar_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_sum_whole (rsp_chan.sum_whole),
   .rsp_sum_num   (rsp_chan.sum_num),
   .rsp_sum_den   (rsp_chan.sum_den),
   .rsp_is_less   (rsp_chan.is_less),
   .rsp_is_equal  (rsp_chan.is_equal)
);

// ===== sim/mfar_tb_if.sv =====
// ----------------------------------------------------------------------------
// mfar_tb_if
// Testbench-side view of the request and response channels.
// ----------------------------------------------------------------------------
// The channel interfaces themselves come with the block; this file holds the
// request item type that the bench drives and records, and the result type.
package mfar_tb_pkg;

   typedef struct packed {
      logic               opcode;
      logic signed [15:0] a_whole;
      logic        [15:0] a_num;
      logic        [15:0] a_den;
      logic signed [15:0] b_whole;
      logic        [15:0] b_num;
      logic        [15:0] b_den;
   } mfar_request_type;

   typedef struct packed {
      logic signed [31:0] sum_whole;
      logic        [31:0] sum_num;
      logic        [31:0] sum_den;
      logic               is_less;
      logic               is_equal;
   } mfar_result_type;

endpackage

// ===== sim/mixed_fraction_add_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// mixed_fraction_add_reduce_tb
// Random and directed check of the mixed number adder and comparator.
// ----------------------------------------------------------------------------
// Requests are offered with random gaps, responses taken with random stalls
// and one long hold-off. Each accepted request is turned into an expected
// response by an exact software sum/compare; responses are checked in order.
module mixed_fraction_add_reduce_tb;

   localparam int N_DIRECTED  = 24;
   localparam int N_RANDOM    = 1626;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 2000;

   class fraction_scoreboard;
      mfar_tb_pkg::mfar_result_type pending[$];
      int mismatches = 0;
      int checked = 0;
      int n_add = 0;
      int n_cmp = 0;

      function automatic longint unsigned euclid(longint unsigned x,
                                                  longint unsigned y);
         longint unsigned t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return x;
      endfunction

      function void note_request(mfar_tb_pkg::mfar_request_type r);
         mfar_tb_pkg::mfar_result_type e;
         longint signed   aw, bw;
         longint unsigned ad, bd, ar, br, d, p, q, s, g, w;
         ad = (r.a_den == 0) ? 1 : r.a_den;
         bd = (r.b_den == 0) ? 1 : r.b_den;
         aw = longint'(r.a_whole) + longint'(r.a_num / ad);
         bw = longint'(r.b_whole) + longint'(r.b_num / bd);
         ar = r.a_num % ad;
         br = r.b_num % bd;
         e = '0;
         if (r.opcode == mfar_pkg::OP_ADD) begin
            n_add++;
            d = ad * bd;
            p = ar * bd;
            q = ad * br;
            s = p + q;
            w = aw + bw;
            if (s >= d) begin
               s -= d;
               w += 1;
            end
            g = euclid(d, s);
            e.sum_whole = w[31:0];
            e.sum_num   = 32'(s / g);
            e.sum_den   = 32'(d / g);
         end else begin
            n_cmp++;
            e.sum_den = 1;
            if (aw != bw) begin
               e.is_less = aw < bw;
            end else begin
               e.is_less  = (ar * bd) < (br * ad);
               e.is_equal = (ar * bd) == (br * ad);
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(mfar_tb_pkg::mfar_result_type got);
         mfar_tb_pkg::mfar_result_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with nothing outstanding: %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch #%0d: exp whole=%0d num=%0d den=%0d lt=%b eq=%b,",
                         " got whole=%0d num=%0d den=%0d lt=%b eq=%b"},
                        checked, e.sum_whole, e.sum_num, e.sum_den, e.is_less,
                        e.is_equal, got.sum_whole, got.sum_num, got.sum_den,
                        got.is_less, got.is_equal);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   mfar_req_if #(.PART_WIDTH(16)) req_chan ();
   mfar_rsp_if                    rsp_chan ();

   mixed_fraction_add_reduce #(.PART_WIDTH(16)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   fraction_scoreboard sb = new();

   int  cycles = 0;
   bit  calm = 0;          // no idling in the closing stretch
   bit  hold_done = 0;     // long receiver hold-off already done

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side: sample on the edge, then re-draw ready.
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result({rsp_chan.sum_whole, rsp_chan.sum_num, rsp_chan.sum_den,
                             rsp_chan.is_less, rsp_chan.is_equal});
         if (!hold_done && sb.n_add + sb.n_cmp >= HOLD_AT) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            rsp_chan.ready <= 0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 0;
         end else if (!calm && stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_chan.ready <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 10) - 1;
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   task automatic send_request(mfar_tb_pkg::mfar_request_type r);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1;
      req_chan.opcode  <= r.opcode;
      req_chan.a_whole <= r.a_whole;
      req_chan.a_num   <= r.a_num;
      req_chan.a_den   <= r.a_den;
      req_chan.b_whole <= r.b_whole;
      req_chan.b_num   <= r.b_num;
      req_chan.b_den   <= r.b_den;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
   endtask

   function automatic logic [15:0] pick_part();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 15));
         3: return 16'h8000 | 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic mfar_tb_pkg::mfar_request_type random_request();
      mfar_tb_pkg::mfar_request_type r;
      r.opcode  = 1'($urandom_range(0, 1));
      r.a_whole = pick_part();
      r.a_num   = pick_part();
      r.a_den   = pick_part();
      r.b_whole = pick_part();
      r.b_num   = pick_part();
      r.b_den   = pick_part();
      // equal-valued operands now and then, so compare sees ties
      if (r.opcode == mfar_pkg::OP_CMP && $urandom_range(0, 3) == 0) begin
         r.b_whole = r.a_whole;
         r.b_num   = r.a_num;
         r.b_den   = r.a_den;
      end
      return r;
   endfunction

   mfar_tb_pkg::mfar_request_type directed[N_DIRECTED] = '{
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd0,     16'd0,     16'sd0,     16'd0,     16'd0},
      '{mfar_pkg::OP_ADD, 16'sd1,     16'd1,     16'd2,     16'sd2,     16'd1,     16'd2},
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd7,     16'd3,     16'sd0,     16'd5,     16'd0},
      '{mfar_pkg::OP_ADD, 16'sd32767, 16'd65535, 16'd1,     16'sd32767, 16'd65535, 16'd1},
      '{mfar_pkg::OP_ADD, 16'sh8000,  16'd0,     16'd65535, 16'sh8000,  16'd0,     16'd65535},
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd65534, 16'd65535, 16'sd0,     16'd65534, 16'd65535},
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd65534, 16'd65535, 16'sd0,     16'd65532, 16'd65533},
      '{mfar_pkg::OP_ADD, -16'sd1,    16'd1,     16'd3,     16'sd0,     16'd2,     16'd3},
      '{mfar_pkg::OP_ADD, 16'sd5,     16'd6,     16'd8,     -16'sd3,    16'd10,    16'd12},
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd65535, 16'd0,     16'sd0,     16'd65535, 16'd0},
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd1,     16'd65521, 16'sd0,     16'd1,     16'd65519},
      '{mfar_pkg::OP_ADD, 16'sd0,     16'd32768, 16'd65535, 16'sd0,     16'd1,     16'd32768},
      '{mfar_pkg::OP_CMP, 16'sd0,     16'd0,     16'd0,     16'sd0,     16'd0,     16'd0},
      '{mfar_pkg::OP_CMP, 16'sd1,     16'd1,     16'd2,     16'sd1,     16'd2,     16'd4},
      '{mfar_pkg::OP_CMP, 16'sd1,     16'd1,     16'd3,     16'sd1,     16'd1,     16'd2},
      '{mfar_pkg::OP_CMP, 16'sd1,     16'd1,     16'd2,     16'sd1,     16'd1,     16'd3},
      '{mfar_pkg::OP_CMP, 16'sh8000,  16'd0,     16'd1,     16'sd32767, 16'd0,     16'd1},
      '{mfar_pkg::OP_CMP, 16'sd32767, 16'd0,     16'd1,     16'sh8000,  16'd0,     16'd1},
      '{mfar_pkg::OP_CMP, 16'sd0,     16'd10,    16'd5,     16'sd2,     16'd0,     16'd0},
      '{mfar_pkg::OP_CMP, 16'sd32767, 16'd65535, 16'd0,     16'sd32767, 16'd65534, 16'd1},
      '{mfar_pkg::OP_CMP, 16'sd0,     16'd65534, 16'd65535, 16'sd0,     16'd65535, 16'd65535},
      '{mfar_pkg::OP_CMP, -16'sd1,    16'd65535, 16'd65535, 16'sd0,     16'd0,     16'd7},
      '{mfar_pkg::OP_CMP, 16'sd0,     16'd65535, 16'd1,     -16'sd1,    16'd65535, 16'd0},
      '{mfar_pkg::OP_ADD, 16'sh8000,  16'd65535, 16'd2,     16'sh8000,  16'd3,     16'd65535}
   };

   initial begin
      int limit;
      req_chan.valid   = 0;
      req_chan.opcode  = mfar_pkg::OP_ADD;
      req_chan.a_whole = 0;
      req_chan.a_num   = 0;
      req_chan.a_den   = 0;
      req_chan.b_whole = 0;
      req_chan.b_num   = 0;
      req_chan.b_den   = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_request(directed[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 200) calm <= 1;
         send_request(random_request());
      end
      req_chan.valid <= 0;
      limit = 0;
      while (sb.pending.size() != 0 && limit < 20000) begin
         @(posedge clock);
         limit++;
      end
      repeat (300) @(posedge clock);
      $display("covered %0d adds and %0d compares, %0d responses checked",
               sb.n_add, sb.n_cmp, sb.checked);
      $display("with random gaps, receiver stalls and one long receiver hold-off");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches,
                  sb.pending.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mfar_pkg.sv
rtl/core/mfar_if.sv
rtl/core/mixed_fraction_add_reduce.sv
rtl/core/mfar_checker.sv
sim/mfar_tb_if.sv
sim/mixed_fraction_add_reduce_tb.sv
